// ===== hdl/mbsg_pkg.sv =====
// ----------------------------------------------------------------------------
// mbsg_pkg
// Shared types and constants for the order-K Markov base sequence generator.
// ----------------------------------------------------------------------------
package mbsg_pkg;

    localparam int HISTORY_BASES = 1;
    localparam int WEIGHT_BITS   = 16;

    localparam int CTX_BITS    = 2 * HISTORY_BASES;
    localparam int TBL_ADDR_W  = CTX_BITS + 2;
    localparam int TABLE_DEPTH = 1 << TBL_ADDR_W;
    localparam int SUM_W       = WEIGHT_BITS + 2;
    localparam int RAND_W      = 32;
    localparam int PROD_W      = SUM_W + RAND_W;
    localparam int LEN_W       = 16;
    localparam int COUNT_W     = 17;
    localparam int BASE_W      = 3;

    localparam logic [BASE_W-1:0] BASE_N = 3'd4;

    localparam logic CFG_BURNIN = 1'b0;
    localparam logic CFG_OUTLEN = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_SEED = 2'd1,
        OP_STEP = 2'd2
    } op_t;

    typedef logic [WEIGHT_BITS-1:0] weight_t;
    typedef weight_t [3:0] row_t;

    typedef struct packed {
        logic                  en;
        logic [TBL_ADDR_W-1:0] addr;
        weight_t               data;
    } tbl_wr_t;

endpackage

// ===== hdl/mbsg_weight_table.sv =====
// ----------------------------------------------------------------------------
// mbsg_weight_table
// Context-by-base weight table, cleared at reset, one row read per cycle.
// ----------------------------------------------------------------------------
module mbsg_weight_table
    import mbsg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  tbl_wr_t             wr,
    input  logic [CTX_BITS-1:0] rd_ctx,
    output row_t                rd_row
);

    weight_t table_reg [TABLE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                table_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            table_reg[wr.addr] <= wr.data;
        end
    end

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            rd_row[b] = table_reg[{rd_ctx, 2'(b)}];
        end
    end

endmodule

// ===== hdl/mbsg_pick.sv =====
// ----------------------------------------------------------------------------
// mbsg_pick
// Base selection: first base whose running weight times 2^32 exceeds
// random times the row sum; N for a zero row.
// ----------------------------------------------------------------------------
module mbsg_pick
    import mbsg_pkg::*;
(
    input  row_t              row,
    input  logic [RAND_W-1:0] random,
    output logic [BASE_W-1:0] base_pick
);

    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  thresh;
    logic [SUM_W-1:0]  cum;
    logic              found;

    always_comb
    begin
        sum = '0;
        for (int b = 0; b < 4; b++)
        begin
            sum = sum + SUM_W'(row[b]);
        end
        prod   = PROD_W'(sum) * PROD_W'(random);
        thresh = prod[PROD_W-1:RAND_W];

        base_pick = BASE_N;
        found     = 1'b0;
        cum       = '0;
        for (int b = 0; b < 4; b++)
        begin
            cum = cum + SUM_W'(row[b]);
            if (!found && (cum > thresh))
            begin
                base_pick = BASE_W'(b);
                found     = 1'b1;
            end
        end
    end

endmodule

// ===== hdl/markov_base_sequence_generator.sv =====
// ----------------------------------------------------------------------------
// markov_base_sequence_generator
// Pipeline: a request registers in s1, a step's result in the output register.
// Throughput: one request per cycle unless the output stalls; the state update
// of one request is seen by the next, and the table row read, sum and multiply
// set the path.
// Reset: asynchronous, clears the weight table, history, count and flags.
// ----------------------------------------------------------------------------
module markov_base_sequence_generator
    import mbsg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [1:0]        context_req,
    input  logic [1:0]        next_base,
    input  logic [15:0]       weight,
    input  logic [RAND_W-1:0] random,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BASE_W-1:0] base,
    output logic              last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [LEN_W-1:0]  cfg_data
);

    logic                s1_valid_reg;
    logic [1:0]          s1_op_reg;
    logic [CTX_BITS-1:0] s1_ctx_reg;
    logic [1:0]          s1_nb_reg;
    weight_t             s1_weight_reg;
    logic [RAND_W-1:0]   s1_random_reg;

    logic [CTX_BITS-1:0] history_reg, history_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                stuck_reg, stuck_next;
    logic [LEN_W-1:0]    burnin_reg;
    logic [LEN_W-1:0]    outlen_reg;

    logic                out_valid_reg;
    logic [BASE_W-1:0]   base_reg;
    logic                last_reg;

    logic                in_accept;
    logic                out_free;
    logic                s1_go;
    logic [COUNT_W-1:0]  total;
    logic [COUNT_W-1:0]  count_inc;
    logic                step_active;
    logic                step_emit;
    logic [BASE_W-1:0]   base_pick;
    logic [BASE_W-1:0]   base_sel;
    row_t                row;
    tbl_wr_t             tbl_wr;

    assign cfg_ready = 1'b1;

    assign total       = COUNT_W'(burnin_reg) + COUNT_W'(outlen_reg);
    assign count_inc   = count_reg + COUNT_W'(1);
    assign step_active = (s1_op_reg == OP_STEP) && (count_reg < total);
    assign step_emit   = step_active && (count_inc > COUNT_W'(burnin_reg));
    assign base_sel    = stuck_reg ? BASE_N : base_pick;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_go     = s1_valid_reg && (!step_emit || out_free);
    assign in_stall  = s1_valid_reg && !s1_go;
    assign in_accept = in_valid && !in_stall;

    assign tbl_wr.en   = s1_go && (s1_op_reg == OP_LOAD);
    assign tbl_wr.addr = {s1_ctx_reg, s1_nb_reg};
    assign tbl_wr.data = s1_weight_reg;

    mbsg_weight_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (tbl_wr),
        .rd_ctx (history_reg),
        .rd_row (row)
    );

    mbsg_pick u_pick (
        .row       (row),
        .random    (s1_random_reg),
        .base_pick (base_pick)
    );

    always_comb
    begin
        history_next = history_reg;
        count_next   = count_reg;
        stuck_next   = stuck_reg;
        if (s1_go)
        begin
            unique case (s1_op_reg)
                OP_LOAD:
                begin
                end
                OP_SEED:
                begin
                    history_next = CTX_BITS'({history_reg, s1_nb_reg});
                    count_next   = '0;
                    stuck_next   = 1'b0;
                end
                OP_STEP:
                begin
                    if (step_active)
                    begin
                        count_next = count_inc;
                        if (!stuck_reg)
                        begin
                            if (base_pick == BASE_N)
                            begin
                                stuck_next = 1'b1;
                            end
                            else
                            begin
                                history_next = CTX_BITS'({history_reg, base_pick[1:0]});
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            history_reg   <= '0;
            count_reg     <= '0;
            stuck_reg     <= 1'b0;
            burnin_reg    <= '0;
            outlen_reg    <= LEN_W'(128);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            history_reg <= history_next;
            count_reg   <= count_next;
            stuck_reg   <= stuck_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_BURNIN: burnin_reg <= cfg_data;
                    CFG_OUTLEN: outlen_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (s1_go && step_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg     <= opcode;
            s1_ctx_reg    <= CTX_BITS'(context_req);
            s1_nb_reg     <= next_base;
            s1_weight_reg <= WEIGHT_BITS'(weight);
            s1_random_reg <= random;
        end
        if (s1_go && step_emit)
        begin
            base_reg <= base_sel;
            last_reg <= (count_inc == total);
        end
    end

    assign out_valid = out_valid_reg;
    assign base      = base_reg;
    assign last      = last_reg;

endmodule

// ===== hdl/mbsg_checker.sv =====
// ----------------------------------------------------------------------------
// mbsg_checker
// Port-level checks for the Markov base sequence generator.
// ----------------------------------------------------------------------------
module mbsg_checker
    import mbsg_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [BASE_W-1:0] base,
    input logic              last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(base) && $stable(last))
        else $error("stalled result changed");

    a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> base <= BASE_N)
        else $error("base code out of range");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output free");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last |=> !out_valid)
        else $error("result after final base");

endmodule

bind markov_base_sequence_generator mbsg_checker u_mbsg_checker (.*);

// ===== bench/tb_markov_base_sequence_generator.sv =====
// ----------------------------------------------------------------------------
// tb_markov_base_sequence_generator
// Self-checking bench for the order-K Markov base sequence generator. Loads
// weight tables, seeds the history and steps the chain under random idle on
// both streams. A local chain predictor with exact integer base selection
// builds the expected bases, and each output is compared in order.
// ----------------------------------------------------------------------------
module tb_markov_base_sequence_generator;
    import mbsg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         HOLD_TICKS = 4;
    localparam int         STALL_MAX  = 14;
    localparam int         WATCHDOG   = 2000;

    typedef struct packed {
        logic [BASE_W-1:0] sym;
        logic              is_last;
    } base_out_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_stall;
    logic [1:0]        opcode      = '0;
    logic [1:0]        context_req = '0;
    logic [1:0]        next_base   = '0;
    logic [15:0]       weight      = '0;
    logic [RAND_W-1:0] random      = '0;
    logic              out_valid;
    logic              out_stall   = 1'b0;
    logic [BASE_W-1:0] base;
    logic              last;
    logic              cfg_valid   = 1'b0;
    logic              cfg_ready;
    logic              cfg_index   = 1'b0;
    logic [LEN_W-1:0]  cfg_data    = '0;

    weight_t             wt_rows [TABLE_DEPTH];
    logic [CTX_BITS-1:0] ctx_hist   = '0;
    logic [COUNT_W-1:0]  gen_count  = '0;
    logic                n_latched  = 1'b0;
    logic [LEN_W-1:0]    burnin_len = '0;
    logic [LEN_W-1:0]    emit_len   = LEN_W'(128);

    base_out_t expected_bases[$];
    int        failures      = 0;
    int        requests_sent = 0;
    bit        no_idle       = 1'b0;
    int        idle_cycles   = 0;

    markov_base_sequence_generator uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .context_req (context_req),
        .next_base   (next_base),
        .weight      (weight),
        .random      (random),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .base        (base),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        foreach (wt_rows[i])
            wt_rows[i] = '0;
    end

    function automatic logic [BASE_W-1:0] choose_base(input logic [CTX_BITS-1:0] ctx,
                                                      input logic [RAND_W-1:0] r);
        logic [63:0] row_total;
        logic [63:0] running;
        logic [63:0] scaled;
        int          b;
        row_total = '0;
        for (b = 0; b < 4; b++)
            row_total += 64'(wt_rows[{ctx, 2'(b)}]);
        if (row_total == 0)
            return BASE_N;
        scaled  = row_total * 64'(r);
        running = '0;
        for (b = 0; b < 4; b++)
        begin
            running += 64'(wt_rows[{ctx, 2'(b)}]);
            if ((running << 32) > scaled)
                return BASE_W'(b);
        end
        return BASE_N;
    endfunction

    task automatic advance_chain(input logic [1:0] op, input logic [1:0] ctx,
                                 input logic [1:0] nb, input logic [15:0] w,
                                 input logic [RAND_W-1:0] r);
        logic [COUNT_W-1:0] total;
        logic [BASE_W-1:0]  pick;
        base_out_t          item;
        total = COUNT_W'(burnin_len) + COUNT_W'(emit_len);
        case (op)
            OP_LOAD:
                wt_rows[{ctx[CTX_BITS-1:0], nb}] = w[WEIGHT_BITS-1:0];
            OP_SEED:
            begin
                ctx_hist  = CTX_BITS'({ctx_hist, nb});
                gen_count = '0;
                n_latched = 1'b0;
            end
            OP_STEP:
            begin
                if (gen_count < total)
                begin
                    if (n_latched)
                        pick = BASE_N;
                    else
                    begin
                        pick = choose_base(ctx_hist, r);
                        if (pick == BASE_N)
                            n_latched = 1'b1;
                        else
                            ctx_hist = CTX_BITS'({ctx_hist, pick[1:0]});
                    end
                    gen_count = gen_count + 1'b1;
                    if (gen_count > COUNT_W'(burnin_len))
                    begin
                        item.sym     = pick;
                        item.is_last = (gen_count == total);
                        expected_bases.push_back(item);
                    end
                end
            end
            default:
                ;
        endcase
    endtask

    task automatic send_request(input logic [1:0] op, input logic [1:0] ctx,
                                input logic [1:0] nb, input logic [15:0] w,
                                input logic [RAND_W-1:0] r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, STALL_MAX);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        context_req <= ctx;
        next_base   <= nb;
        weight      <= w;
        random      <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
        advance_chain(op, ctx, nb, w, r);
    endtask

    task automatic send_step(input logic [RAND_W-1:0] r);
        send_request(OP_STEP, 2'($urandom), 2'($urandom), 16'($urandom), r);
    endtask

    task automatic send_load(input logic [1:0] ctx, input logic [1:0] nb, input logic [15:0] w);
        send_request(OP_LOAD, ctx, nb, w, $urandom);
    endtask

    task automatic send_seed(input logic [1:0] nb);
        send_request(OP_SEED, 2'($urandom), nb, 16'($urandom), $urandom);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_bases.size() != 0)
            @(posedge clk);
        repeat (HOLD_TICKS) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [LEN_W-1:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_BURNIN)
            burnin_len = val;
        else
            emit_len = val;
    endtask

    function automatic logic [15:0] draw_weight();
        case ($urandom_range(0, 7))
            0, 1:    return 16'd0;
            2:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_random_table(input bit partial);
        bit zero_row;
        for (int c = 0; c < 4; c++)
        begin
            zero_row = ($urandom_range(0, 5) == 0);
            for (int b = 0; b < 4; b++)
            begin
                if (!partial || $urandom_range(0, 2) == 0)
                    send_load(2'(c), 2'(b), zero_row ? 16'd0 : draw_weight());
            end
        end
    endtask

    // empty table after reset: every step falls to N, default lengths
    task automatic test_empty_table();
        send_step(32'h0000_0000);
        send_step(32'hFFFF_FFFF);
        send_request(OP_UNUSED, 2'd3, 2'd3, 16'hFFFF, 32'hFFFF_FFFF);
        send_seed(2'd3);
        send_step($urandom);
    endtask

    task automatic test_base_selection();
        for (int b = 0; b < 4; b++)
            send_load(2'd0, 2'(b), 16'hFFFF);
        send_load(2'd1, 2'd0, 16'd0);
        send_load(2'd1, 2'd1, 16'd0);
        send_load(2'd1, 2'd2, 16'd0);
        send_load(2'd1, 2'd3, 16'd1);
        send_load(2'd3, 2'd3, 16'd0);
        send_seed(2'd0);
        send_step(32'h0000_0000);
        send_step(32'h8000_0000);
        send_seed(2'd0);
        send_step(32'hFFFF_FFFF);
        send_step($urandom);
        send_step($urandom);
        send_seed(2'd1);
        send_step(32'hFFFF_FFFF);
    endtask

    task automatic test_burnin_window();
        write_register(CFG_BURNIN, 16'd1);
        write_register(CFG_OUTLEN, 16'd2);
        for (int b = 0; b < 4; b++)
            send_load(2'd3, 2'(b), 16'(b + 1));
        send_seed(2'd0);
        repeat (5) send_step($urandom);
        write_register(CFG_OUTLEN, 16'd0);
        send_seed(2'd0);
        repeat (3) send_step($urandom);
        write_register(CFG_BURNIN, 16'd0);
        send_seed(2'd2);
        repeat (2) send_step($urandom);
    endtask

    task automatic test_length_extremes();
        write_register(CFG_BURNIN, 16'hFFFF);
        write_register(CFG_OUTLEN, 16'd2);
        for (int c = 0; c < 4; c++)
            for (int b = 0; b < 4; b++)
                send_load(2'(c), 2'(b), 16'($urandom_range(1, 65535)));
        no_idle = 1'b1;
        send_seed(2'($urandom));
        repeat (20) send_step($urandom);
        no_idle = 1'b0;
        write_register(CFG_BURNIN, 16'd0);
        write_register(CFG_OUTLEN, 16'hFFFF);
        send_seed(2'($urandom));
        repeat (20) send_step($urandom);
    endtask

    task automatic test_random_traffic();
        int target;
        int phase;
        target = requests_sent + 300;
        phase  = 0;
        while (requests_sent < target)
        begin
            no_idle = ($urandom_range(0, 5) == 0);
            if (phase == 0 || $urandom_range(0, 3) == 0)
            begin
                write_register(CFG_BURNIN, 16'($urandom_range(0, 8)));
                write_register(CFG_OUTLEN, 16'($urandom_range(1, 40)));
            end
            else if (phase == 2 || $urandom_range(0, 4) == 0)
                drain_results();
            load_random_table(phase != 0 && $urandom_range(0, 1) == 0);
            send_seed(2'($urandom));
            repeat ($urandom_range(8, 40))
            begin
                case ($urandom_range(0, 15))
                    0:       send_request(OP_UNUSED, 2'($urandom), 2'($urandom),
                                          16'($urandom), $urandom);
                    1:       send_load(2'($urandom), 2'($urandom), draw_weight());
                    2:       send_seed(2'($urandom));
                    default: send_step($urandom);
                endcase
            end
            phase++;
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        int stall_left;
        base_out_t want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_bases.size() == 0)
                begin
                    $error("unexpected result: base=%0d last=%0d", base, last);
                    failures++;
                end
                else
                begin
                    want = expected_bases.pop_front();
                    if (base !== want.sym)
                    begin
                        $error("base: expected %0d, got %0d", want.sym, base);
                        failures++;
                    end
                    if (last !== want.is_last)
                    begin
                        $error("last: expected %0d, got %0d", want.is_last, last);
                        failures++;
                    end
                end
                stall_left = no_idle ? 0 : $urandom_range(0, STALL_MAX);
            end
            else if (stall_left > 0)
                stall_left--;
            out_stall <= (stall_left != 0);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                    (cfg_valid && cfg_ready))
                    idle_cycles = 0;
                else
                    idle_cycles++;
                if (idle_cycles >= WATCHDOG)
                begin
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_base_selection();
        test_burnin_window();
        test_length_extremes();
        test_random_traffic();
        drain_results();
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
